>>> rtl/clh_pkg.sv
// shared types and constants for the console line editor
// no dependencies
`timescale 1ns / 1ps

package clh_pkg;

    localparam int LINE_LEN_DEF      = 32;
    localparam int HISTORY_LINES_DEF = 8;
    localparam int Q_DEPTH           = 2;

    // console byte codes
    localparam logic [7:0] B_ESC   = 8'h1b;
    localparam logic [7:0] B_LBRK  = 8'h5b;
    localparam logic [7:0] B_UP    = 8'h41;
    localparam logic [7:0] B_DOWN  = 8'h42;
    localparam logic [7:0] B_RIGHT = 8'h43;
    localparam logic [7:0] B_LEFT  = 8'h44;
    localparam logic [7:0] B_DEL   = 8'h7f;
    localparam logic [7:0] B_BS    = 8'h08;
    localparam logic [7:0] B_CR    = 8'h0d;
    localparam logic [7:0] B_LF    = 8'h0a;

    // escape phases
    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_ESC    = 2'd1;
    localparam logic [1:0] PH_CSI    = 2'd2;

    // editor commands
    localparam logic [2:0] OP_TYPE  = 3'd0;
    localparam logic [2:0] OP_BS    = 3'd1;
    localparam logic [2:0] OP_TERM  = 3'd2;
    localparam logic [2:0] OP_UP    = 3'd3;
    localparam logic [2:0] OP_DOWN  = 3'd4;
    localparam logic [2:0] OP_RIGHT = 3'd5;
    localparam logic [2:0] OP_LEFT  = 3'd6;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/clh_front.sv
// front end: escape sequence parser and byte classifier
// depends on clh_pkg
`timescale 1ns / 1ps

module clh_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  clh_pkg::q_status_t qs,
    output logic             push,
    output clh_pkg::cmd_t    push_cmd
);

    logic [1:0] esc_reg;
    logic [1:0] esc_next;
    logic       accept;
    logic       has_cmd;
    logic [2:0] op;
    logic [2:0] plain_op;

    assign in_stall = qs.full;
    assign accept   = in_valid && !qs.full;

    always_comb
    begin
        if (rx_byte == clh_pkg::B_CR || rx_byte == clh_pkg::B_LF)
            plain_op = clh_pkg::OP_TERM;
        else if (rx_byte == clh_pkg::B_DEL || rx_byte == clh_pkg::B_BS)
            plain_op = clh_pkg::OP_BS;
        else
            plain_op = clh_pkg::OP_TYPE;
    end

    always_comb
    begin
        esc_next = esc_reg;
        has_cmd  = 1'b0;
        op       = plain_op;
        if (rx_byte == 8'd0)
        begin
            has_cmd = 1'b0;
        end
        else if (rx_byte == clh_pkg::B_ESC)
        begin
            esc_next = clh_pkg::PH_ESC;
        end
        else
        begin
            esc_next = clh_pkg::PH_NORMAL;
            unique case (esc_reg)
                clh_pkg::PH_ESC:
                begin
                    if (rx_byte == clh_pkg::B_LBRK)
                        esc_next = clh_pkg::PH_CSI;
                    else
                        has_cmd = 1'b1;
                end
                clh_pkg::PH_CSI:
                begin
                    has_cmd = 1'b1;
                    if (rx_byte == clh_pkg::B_UP)
                        op = clh_pkg::OP_UP;
                    else if (rx_byte == clh_pkg::B_DOWN)
                        op = clh_pkg::OP_DOWN;
                    else if (rx_byte == clh_pkg::B_RIGHT)
                        op = clh_pkg::OP_RIGHT;
                    else if (rx_byte == clh_pkg::B_LEFT)
                        op = clh_pkg::OP_LEFT;
                    else
                        has_cmd = 1'b0;  // unknown final byte is swallowed
                end
                default:
                begin
                    has_cmd = 1'b1;
                end
            endcase
        end
    end

    assign push          = accept && has_cmd;
    assign push_cmd.op   = op;
    assign push_cmd.data = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            esc_reg <= clh_pkg::PH_NORMAL;
        else if (accept)
            esc_reg <= esc_next;
    end

endmodule

>>> rtl/clh_cmd_q.sv
// short command queue between the parser and the editor engine
// depends on clh_pkg
`timescale 1ns / 1ps

module clh_cmd_q (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  clh_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output clh_pkg::cmd_t      head,
    output clh_pkg::q_status_t qs
);

    localparam int PW = (clh_pkg::Q_DEPTH > 1) ? $clog2(clh_pkg::Q_DEPTH) : 1;
    localparam int CNTW = $clog2(clh_pkg::Q_DEPTH + 1);

    clh_pkg::cmd_t  q_reg [clh_pkg::Q_DEPTH];
    logic [PW-1:0]  wp_reg;
    logic [PW-1:0]  rp_reg;
    logic [CNTW-1:0] cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign qs.full  = (cnt_reg == CNTW'(clh_pkg::Q_DEPTH));
    assign qs.empty = (cnt_reg == '0);
    assign do_push  = push && !qs.full;
    assign do_pop   = pop && !qs.empty;
    assign head     = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= (wp_reg == PW'(clh_pkg::Q_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= (rp_reg == PW'(clh_pkg::Q_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> rtl/clh_back.sv
// editor engine: line buffer, history store, commit and emit sequencer
// depends on clh_pkg
`timescale 1ns / 1ps

module clh_back #(
    parameter int LINE_LEN      = clh_pkg::LINE_LEN_DEF,
    parameter int HISTORY_LINES = clh_pkg::HISTORY_LINES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  clh_pkg::cmd_t      cmd,
    input  clh_pkg::q_status_t qs,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         line_byte,
    output logic               line_last
);

    localparam int CW   = $clog2(LINE_LEN);
    localparam int HCW  = $clog2(HISTORY_LINES + 1);
    localparam int HIW  = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
    localparam int AW   = $clog2(HISTORY_LINES * LINE_LEN);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COPY  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_E_RD  = 3'd4;
    localparam logic [2:0] S_E_LD  = 3'd5;
    localparam logic [2:0] S_E_OUT = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       cursor_reg, cursor_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [HCW-1:0]      hcount_reg, hcount_next;
    logic [HCW-1:0]      hcur_reg, hcur_next;
    logic [HIW-1:0]      base_reg, base_next;
    logic [HIW-1:0]      row_reg, row_next;
    logic [CW:0]         w_reg, w_next;
    logic                p_vld_reg, p_vld_next;
    logic [CW-1:0]       p_idx_reg, p_idx_next;
    logic                found_reg, found_next;
    logic [CW-1:0]       flen_reg, flen_next;
    logic                ok_reg, ok_next;
    logic                dup_reg, dup_next;
    logic [7:0]          term_reg, term_next;
    logic [CW-1:0]       e_reg, e_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;
    logic [LINE_LEN-1:0] bv_reg, bv_next;

    logic [7:0]          buf_mem [LINE_LEN];
    logic [7:0]          hist_mem [HISTORY_LINES * LINE_LEN];
    logic [7:0]          bufq_reg;
    logic                bvq_reg;
    logic [7:0]          histq_reg;
    logic [7:0]          buf_rdata;

    logic                buf_we;
    logic [CW-1:0]       buf_waddr;
    logic [7:0]          buf_wdata;
    logic [CW-1:0]       buf_raddr;
    logic                hist_we;
    logic [AW-1:0]       hist_waddr;
    logic [7:0]          hist_wdata;
    logic [AW-1:0]       hist_raddr;

    logic                issue;
    logic                walk_end;
    logic                full;
    logic [HCW-1:0]      down_sel;
    logic                ok_fin;
    logic                dup_fin;
    logic [7:0]          want;

    // logical history index to physical row of the circular store
    function automatic logic [HIW-1:0] phys(input logic [HIW-1:0] b,
                                            input logic [HIW-1:0] i);
        logic [HIW:0] s;
        begin
            s = {1'b0, b} + {1'b0, i};
            if (s >= (HIW + 1)'(HISTORY_LINES))
                s = s - (HIW + 1)'(HISTORY_LINES);
            return s[HIW-1:0];
        end
    endfunction

    function automatic logic [AW-1:0] haddr(input logic [HIW-1:0] r,
                                            input logic [CW-1:0] c);
        begin
            return AW'(r) * AW'(LINE_LEN) + AW'(c);
        end
    endfunction

    assign buf_rdata = bvq_reg ? bufq_reg : 8'd0;
    assign issue     = (w_reg < (CW + 1)'(LINE_LEN));
    assign walk_end  = p_vld_reg && (p_idx_reg == CW'(LINE_LEN - 1));
    assign full      = (hcount_reg == HCW'(HISTORY_LINES));
    assign down_sel  = ((HCW + 1)'(hcur_reg) + 1'b1 < (HCW + 1)'(hcount_reg)) ?
                       hcur_reg + 1'b1 : hcount_reg - 1'b1;
    assign want      = (p_idx_reg < cursor_reg) ? buf_rdata : 8'd0;

    always_comb
    begin
        ok_fin  = ok_reg;
        dup_fin = dup_reg;
        if (p_vld_reg)
        begin
            if (p_idx_reg < cursor_reg)
            begin
                if (buf_rdata == 8'd0)
                    ok_fin = 1'b0;
            end
            else if (p_idx_reg == cursor_reg)
            begin
                if (buf_rdata != 8'd0)
                    ok_fin = 1'b0;
            end
            if (histq_reg != want)
                dup_fin = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        len_next       = len_reg;
        hcount_next    = hcount_reg;
        hcur_next      = hcur_reg;
        base_next      = base_reg;
        row_next       = row_reg;
        w_next         = w_reg;
        p_vld_next     = 1'b0;
        p_idx_next     = w_reg[CW-1:0];
        found_next     = found_reg;
        flen_next      = flen_reg;
        ok_next        = ok_reg;
        dup_next       = dup_reg;
        term_next      = term_reg;
        e_next         = e_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        bv_next        = bv_reg;
        pop            = 1'b0;
        buf_we         = 1'b0;
        buf_waddr      = cursor_reg;
        buf_wdata      = cmd.data;
        buf_raddr      = w_reg[CW-1:0];
        hist_we        = 1'b0;
        hist_waddr     = haddr(row_reg, p_idx_reg);
        hist_wdata     = want;
        hist_raddr     = haddr(row_reg, w_reg[CW-1:0]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (!qs.empty)
                begin
                    pop = 1'b1;
                    w_next     = '0;
                    found_next = 1'b0;
                    unique case (cmd.op)
                        clh_pkg::OP_TYPE:
                        begin
                            if (cursor_reg < CW'(LINE_LEN - 1))
                            begin
                                buf_we              = 1'b1;
                                bv_next[cursor_reg] = 1'b1;
                                cursor_next         = cursor_reg + 1'b1;
                                len_next            = cursor_reg + 1'b1;
                            end
                            else
                            begin
                                cursor_next = '0;
                                len_next    = '0;
                            end
                        end
                        clh_pkg::OP_BS:
                        begin
                            // an invalid entry reads as zero, so clearing the bit deletes
                            if (cursor_reg != '0)
                            begin
                                bv_next[cursor_reg - 1'b1] = 1'b0;
                                cursor_next = cursor_reg - 1'b1;
                                len_next    = cursor_reg - 1'b1;
                            end
                        end
                        clh_pkg::OP_RIGHT:
                        begin
                            if (cursor_reg < len_reg)
                                cursor_next = cursor_reg + 1'b1;
                        end
                        clh_pkg::OP_LEFT:
                        begin
                            if (cursor_reg != '0)
                                cursor_next = cursor_reg - 1'b1;
                        end
                        clh_pkg::OP_UP:
                        begin
                            if (hcur_reg != '0)
                            begin
                                hcur_next  = hcur_reg - 1'b1;
                                row_next   = phys(base_reg, HIW'(hcur_reg - 1'b1));
                                state_next = S_COPY;
                            end
                        end
                        clh_pkg::OP_DOWN:
                        begin
                            if (hcount_reg != '0)
                            begin
                                hcur_next  = down_sel;
                                row_next   = phys(base_reg, HIW'(down_sel));
                                state_next = S_COPY;
                            end
                        end
                        clh_pkg::OP_TERM:
                        begin
                            term_next = cmd.data;
                            if (cursor_reg == '0)
                            begin
                                bv_next     = '0;
                                cursor_next = '0;
                                len_next    = '0;
                            end
                            else
                            begin
                                row_next   = phys(base_reg, HIW'(hcount_reg - 1'b1));
                                ok_next    = 1'b1;
                                dup_next   = (hcount_reg != '0);
                                state_next = S_CHECK;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            S_COPY:
            begin
                if (issue)
                begin
                    w_next     = w_reg + 1'b1;
                    p_vld_next = 1'b1;
                end
                if (p_vld_reg)
                begin
                    buf_we             = 1'b1;
                    buf_waddr          = p_idx_reg;
                    buf_wdata          = histq_reg;
                    bv_next[p_idx_reg] = 1'b1;
                    if (!found_reg && histq_reg == 8'd0)
                    begin
                        found_next = 1'b1;
                        flen_next  = p_idx_reg;
                    end
                end
                if (walk_end)
                begin
                    cursor_next = found_reg ? flen_reg : p_idx_reg;
                    len_next    = found_reg ? flen_reg : p_idx_reg;
                    state_next  = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (issue)
                begin
                    w_next     = w_reg + 1'b1;
                    p_vld_next = 1'b1;
                end
                ok_next  = ok_fin;
                dup_next = dup_fin;
                if (walk_end)
                begin
                    w_next = '0;
                    e_next = '0;
                    if (!ok_fin)
                    begin
                        bv_next     = '0;
                        cursor_next = '0;
                        len_next    = '0;
                        state_next  = S_IDLE;
                    end
                    else if (dup_fin)
                    begin
                        hcur_next  = hcount_reg;
                        state_next = S_E_RD;
                    end
                    else
                    begin
                        row_next   = full ? base_reg : phys(base_reg, HIW'(hcount_reg));
                        state_next = S_STORE;
                    end
                end
            end
            S_STORE:
            begin
                if (issue)
                begin
                    w_next     = w_reg + 1'b1;
                    p_vld_next = 1'b1;
                end
                if (p_vld_reg)
                    hist_we = 1'b1;
                if (walk_end)
                begin
                    if (full)
                    begin
                        base_next = phys(base_reg, HIW'(1));
                        hcur_next = hcount_reg;
                    end
                    else
                    begin
                        hcount_next = hcount_reg + 1'b1;
                        hcur_next   = hcount_reg + 1'b1;
                    end
                    e_next     = '0;
                    state_next = S_E_RD;
                end
            end
            S_E_RD:
            begin
                buf_raddr = e_reg;
                if (e_reg < cursor_reg)
                begin
                    state_next = S_E_LD;
                end
                else
                begin
                    out_byte_next  = term_reg;
                    out_last_next  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_E_OUT;
                end
            end
            S_E_LD:
            begin
                out_byte_next  = buf_rdata;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
                state_next     = S_E_OUT;
            end
            S_E_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        bv_next     = '0;
                        cursor_next = '0;
                        len_next    = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        state_next = S_E_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_waddr] <= buf_wdata;
        bufq_reg <= buf_mem[buf_raddr];
        bvq_reg  <= bv_reg[buf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        histq_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            len_reg       <= '0;
            hcount_reg    <= '0;
            hcur_reg      <= '0;
            base_reg      <= '0;
            w_reg         <= '0;
            p_vld_reg     <= 1'b0;
            found_reg     <= 1'b0;
            ok_reg        <= 1'b0;
            dup_reg       <= 1'b0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            bv_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            len_reg       <= len_next;
            hcount_reg    <= hcount_next;
            hcur_reg      <= hcur_next;
            base_reg      <= base_next;
            w_reg         <= w_next;
            p_vld_reg     <= p_vld_next;
            found_reg     <= found_next;
            ok_reg        <= ok_next;
            dup_reg       <= dup_next;
            e_reg         <= e_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            bv_reg        <= bv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        p_idx_reg    <= p_idx_next;
        flen_reg     <= flen_next;
        term_reg     <= term_next;
        out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign line_byte = out_byte_reg;
    assign line_last = out_last_reg;

`ifndef SYNTH
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CW'(LINE_LEN - 1))
        else $error("cursor beyond last usable column");
    a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_E_OUT)
        else $error("result shown outside emit");
    a_hist_order: assert property (@(posedge clk) disable iff (!rst_n)
        hcur_reg <= hcount_reg && hcount_reg <= HCW'(HISTORY_LINES))
        else $error("history cursor or count out of range");
    a_clear_after_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_E_OUT && !out_stall && out_last_reg)
        |=> (cursor_reg == '0 && bv_reg == '0 && state_reg == S_IDLE))
        else $error("buffer not cleared after terminator");
`endif

endmodule

>>> rtl/console_line_editor_history.sv
// top level of the console line editor with command history
// depends on clh_pkg, clh_front, clh_cmd_q, clh_back
`timescale 1ns / 1ps

// console line editor: one received byte per accepted request on rx_byte.
// the front parses ESC [ A/B/C/D and classifies bytes into commands, which
// go through a two-entry queue to the editor engine, so bytes keep being
// taken while a commit is emitting, until the queue is full. typing,
// backspace and cursor moves are done in the idle state as the command is
// popped. a history recall walks one stored line through the history memory
// read port into the line buffer. a commit (CR or LF) walks the line buffer
// and the newest history entry for the check, writes the new entry unless it
// repeats the newest one, then emits the line byte by byte (read, load,
// output) and then the terminator, each held until taken on line_byte /
// line_last. each walk is serial, set by the single read port of the line
// buffer and of the history memory. history is a circular store, so dropping
// the oldest line moves a base pointer only. no clearing pass is needed after
// reset.

module console_line_editor_history #(
    parameter int LINE_LEN      = clh_pkg::LINE_LEN_DEF,
    parameter int HISTORY_LINES = clh_pkg::HISTORY_LINES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // received console bytes
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // committed line bytes, terminator flagged by line_last
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] line_byte,
    output logic       line_last
);

    clh_pkg::q_status_t qs;
    clh_pkg::cmd_t      push_cmd;
    clh_pkg::cmd_t      head;
    logic               push;
    logic               pop;

    // parser and classifier
    clh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .qs       (qs),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decoupling queue
    clh_cmd_q u_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qs       (qs)
    );

    // editor engine with line buffer and history store
    clh_back #(
        .LINE_LEN      (LINE_LEN),
        .HISTORY_LINES (HISTORY_LINES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head),
        .qs        (qs),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .line_byte (line_byte),
        .line_last (line_last)
    );

endmodule
